[hw/rtl/shb_pkg.sv]
package shb_pkg;

   // Field widths of the hash datapath.
   localparam int unsigned HASH_W = 29;
   localparam int unsigned CHAR_W = 8;
   // The unreduced sum stays below 2^31.
   localparam int unsigned SUM_W = 31;
   localparam int unsigned CNT_W = $clog2(HASH_W + 1);

   // Default width of the bucket count register.
   localparam int unsigned BUCKET_BITS_DEF = 16;

   // Hash constants: the per-character multiplier and the prime modulus.
   localparam logic [SUM_W-1:0] HASH_MUL_K  = 31'd314159;
   localparam logic [SUM_W-1:0] HASH_MOD_P  = 31'd516595003;
   localparam logic [SUM_W-1:0] HASH_MOD_2P = 31'd1033190006;

endpackage

[hw/rtl/shb_mod_unit.sv]
module shb_mod_unit
   import shb_pkg::*;
#(
   parameter int unsigned BUCKET_BITS = BUCKET_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   take,
   input  logic [HASH_W-1:0]      dividend,
   input  logic [BUCKET_BITS-1:0] divisor,
   output logic                   done,
   output logic [BUCKET_BITS-1:0] remainder
);

   logic                   busy_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [HASH_W-1:0]      shift_ff;
   logic [BUCKET_BITS-1:0] divisor_ff;
   logic [BUCKET_BITS-1:0] rem_ff;
   logic [BUCKET_BITS:0]   trial;
   logic [BUCKET_BITS-1:0] rem_in;

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   always_comb begin
      trial = {rem_ff, shift_ff[HASH_W-1]};
      if (trial >= {1'b0, divisor_ff}) begin
         rem_in = BUCKET_BITS'(trial - {1'b0, divisor_ff});
      end else begin
         rem_in = trial[BUCKET_BITS-1:0];
      end
   end

   // Control: load on start, step once per cycle, hold the result until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= CNT_W'(HASH_W);
      end else if (busy_ff && count_ff != '0) begin
         count_ff <= count_ff - CNT_W'(1);
      end else if (take) begin
         busy_ff <= 1'b0;
      end
   end

   // Datapath: dividend bits leave the shift register one per cycle.
   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff   <= dividend;
         divisor_ff <= divisor;
         rem_ff     <= '0;
      end else if (busy_ff && count_ff != '0) begin
         shift_ff <= {shift_ff[HASH_W-2:0], 1'b0};
         rem_ff   <= rem_in;
      end
   end

   assign done      = busy_ff && (count_ff == '0);
   assign remainder = rem_ff;

endmodule

[hw/rtl/string_hash_bucket_core.sv]
// Character words (nonzero bytes): each is summed into sum_ff, then reduced into the
// running hash in ST_REDUCE; no new word is taken until that is done. Terminator word:
// the remainder by bucket_count is formed one dividend bit per step over all 29 hash bits,
// the result word is loaded once the result register is empty or being drained, then the next word is taken.
// Synchronous active-high reset clears the running hash, sets bucket_count to 1 and
// empties the result register.
module string_hash_bucket_core
   import shb_pkg::*;
#(
   parameter int unsigned BUCKET_BITS = BUCKET_BITS_DEF,
   localparam int unsigned RSP_W = ((BUCKET_BITS + HASH_W + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input words.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [CHAR_W-1:0]      req_tdata,   // char_code [7:0]
   // Result words.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata,   // bucket, then name_hash (29 bits), zero padded
   // Bucket count register.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [BUCKET_BITS-1:0] csr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_REDUCE, ST_DIVIDE} state_type;

   state_type              state_ff;
   logic [HASH_W-1:0]      hash_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [HASH_W-1:0]      final_hash_ff;
   logic [BUCKET_BITS-1:0] divisor_ff;
   logic                   rsp_valid_ff;
   logic [BUCKET_BITS-1:0] rsp_bucket_ff;
   logic [HASH_W-1:0]      rsp_hash_ff;

   logic [SUM_W-1:0]       sum_in;
   logic [HASH_W-1:0]      hash_in;
   logic                   req_accept;
   logic                   end_of_name;
   logic                   div_done;
   logic                   div_take;
   logic [BUCKET_BITS-1:0] div_rem;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign end_of_name = (req_tdata == '0);
   assign csr_ready   = 1'b1;

   // Unreduced update: h + (h xor h/2) + K * c.
   assign sum_in = SUM_W'(hash_ff) + SUM_W'(hash_ff ^ (hash_ff >> 1))
                 + HASH_MUL_K * SUM_W'(req_tdata);

   // The sum stays below three times the prime, so at most two subtractions.
   always_comb begin
      if (sum_ff >= HASH_MOD_2P) begin
         hash_in = HASH_W'(sum_ff - HASH_MOD_2P);
      end else if (sum_ff >= HASH_MOD_P) begin
         hash_in = HASH_W'(sum_ff - HASH_MOD_P);
      end else begin
         hash_in = sum_ff[HASH_W-1:0];
      end
   end

   // The result register may be loaded once it is empty or being drained.
   assign div_take = (state_ff == ST_DIVIDE) && div_done && (!rsp_valid_ff || rsp_tready);

   // Bucket count register; zero behaves as one.
   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= BUCKET_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         divisor_ff <= (csr_data == '0) ? BUCKET_BITS'(1) : csr_data;
      end
   end

   // Sequencer with the running hash and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A word drained while a new one is loaded leaves the register full.
         if (rsp_valid_ff && rsp_tready && !div_take) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (end_of_name) begin
                     final_hash_ff <= hash_ff;
                     hash_ff       <= '0;
                     state_ff      <= ST_DIVIDE;
                  end else begin
                     sum_ff   <= sum_in;
                     state_ff <= ST_REDUCE;
                  end
               end
            end
            ST_REDUCE: begin
               hash_ff  <= hash_in;
               state_ff <= ST_IDLE;
            end
            ST_DIVIDE: begin
               if (div_take) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_bucket_ff <= div_rem;
                  rsp_hash_ff   <= final_hash_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Bit-serial remainder of the final hash by the bucket count.
   shb_mod_unit #(
      .BUCKET_BITS(BUCKET_BITS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept && end_of_name),
      .take      (div_take),
      .dividend  (hash_ff),
      .divisor   (divisor_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_hash_ff, rsp_bucket_ff});

endmodule

[hw/rtl/shb_checker.sv]
module shb_checker
   import shb_pkg::*;
#(
   parameter int unsigned BUCKET_BITS = BUCKET_BITS_DEF,
   localparam int unsigned RSP_W = ((BUCKET_BITS + HASH_W + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // A stalled result word keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Every accepted word keeps the block busy for at least the next cycle.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted in back-to-back cycles");

   // The reported hash is always reduced below the prime.
   a_hash_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[BUCKET_BITS+HASH_W-1:BUCKET_BITS] < HASH_MOD_P)
      else $error("name hash not reduced");

   // Reset leaves no result word pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word pending after reset");

endmodule

bind string_hash_bucket_core shb_checker #(
   .BUCKET_BITS(BUCKET_BITS)
) u_shb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
